### sv/yrw_pkg.sv
package yrw_pkg;

    localparam int SCREEN_WIDTH_DEF  = 400;
    localparam int SCREEN_HEIGHT_DEF = 240;

    localparam int FRAME_WIDTH_RST  = 400;
    localparam int FRAME_HEIGHT_RST = 240;

    localparam int SAMPLE_W = 8;
    localparam int COORD_W  = 12;
    localparam int PIXEL_W  = 16;
    localparam int ADDR_W   = 17;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    typedef struct packed {
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
    } yrw_area_t;

    typedef struct packed {
        logic adv1;
        logic adv2;
        logic adv3;
    } yrw_adv_t;

endpackage

### sv/yrw_cfg.sv
module yrw_cfg #(
    parameter int SCREEN_WIDTH  = yrw_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = yrw_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [yrw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [yrw_pkg::CFG_DATA_W-1:0]  cfg_data,
    output yrw_pkg::yrw_area_t              area
);
    import yrw_pkg::*;

    localparam int W_RST = (FRAME_WIDTH_RST < SCREEN_WIDTH) ? FRAME_WIDTH_RST : SCREEN_WIDTH;
    localparam int H_RST = (FRAME_HEIGHT_RST < SCREEN_HEIGHT) ? FRAME_HEIGHT_RST : SCREEN_HEIGHT;
    localparam logic [COORD_W:0] SW_EXT = (COORD_W+1)'(SCREEN_WIDTH);
    localparam logic [COORD_W:0] SH_EXT = (COORD_W+1)'(SCREEN_HEIGHT);

    logic [COORD_W-1:0] width_reg, width_next;
    logic [COORD_W-1:0] height_reg, height_next;
    logic [COORD_W-1:0] clip_w, clip_h;

    // store the size already clipped to the screen
    assign clip_w = ({1'b0, cfg_data} < SW_EXT) ? cfg_data : COORD_W'(SCREEN_WIDTH);
    assign clip_h = ({1'b0, cfg_data} < SH_EXT) ? cfg_data : COORD_W'(SCREEN_HEIGHT);

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_next  = clip_w;
                REG_FRAME_HEIGHT: height_next = clip_h;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= COORD_W'(W_RST);
            height_reg <= COORD_W'(H_RST);
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    assign area.width  = width_reg;
    assign area.height = height_reg;

endmodule

### sv/yrw_color.sv
module yrw_color (
    input  logic                           aclk,
    input  yrw_pkg::yrw_adv_t              adv,
    input  logic [yrw_pkg::SAMPLE_W-1:0]   luma,
    input  logic [yrw_pkg::SAMPLE_W-1:0]   chroma_blue,
    input  logic [yrw_pkg::SAMPLE_W-1:0]   chroma_red,
    output logic [yrw_pkg::PIXEL_W-1:0]    pixel_rgb565
);
    import yrw_pkg::*;

    localparam int SUM_W = 19;
    localparam int SHR_W = SUM_W - 8;

    logic signed [8:0] y_c, u_c, v_c;

    logic signed [17:0] c_reg, c_next;
    logic signed [16:0] rv_reg, rv_next;
    logic signed [15:0] gu_reg, gu_next;
    logic signed [15:0] gv_reg, gv_next;
    logic signed [17:0] bu_reg, bu_next;

    logic signed [SUM_W-1:0] r_sum_reg, r_sum_next;
    logic signed [SUM_W-1:0] g_sum_reg, g_sum_next;
    logic signed [SUM_W-1:0] b_sum_reg, b_sum_next;

    logic [PIXEL_W-1:0] pixel_reg, pixel_next;
    logic [7:0] r8, g8, b8;

    function automatic logic [7:0] shift_clamp(input logic signed [SUM_W-1:0] v);
        logic signed [SHR_W-1:0] s;
        s = SHR_W'(v >>> 8);
        if (s < 0) begin
            return 8'd0;
        end else if (s > SHR_W'(255)) begin
            return 8'd255;
        end
        return s[7:0];
    endfunction

    assign y_c = $signed({1'b0, luma}) - 9'sd16;
    assign u_c = $signed({1'b0, chroma_blue}) - 9'sd128;
    assign v_c = $signed({1'b0, chroma_red}) - 9'sd128;

    assign c_next  = 18'(y_c) * 18'sd298 + 18'sd128;
    assign rv_next = 17'(v_c) * 17'sd409;
    assign gu_next = 16'(u_c) * 16'sd100;
    assign gv_next = 16'(v_c) * 16'sd208;
    assign bu_next = 18'(u_c) * 18'sd516;

    assign r_sum_next = SUM_W'(c_reg) + SUM_W'(rv_reg);
    assign g_sum_next = SUM_W'(c_reg) - SUM_W'(gu_reg) - SUM_W'(gv_reg);
    assign b_sum_next = SUM_W'(c_reg) + SUM_W'(bu_reg);

    assign r8 = shift_clamp(r_sum_reg);
    assign g8 = shift_clamp(g_sum_reg);
    assign b8 = shift_clamp(b_sum_reg);
    assign pixel_next = {r8[7:3], g8[7:2], b8[7:3]};

    always_ff @(posedge aclk) begin
        if (adv.adv1) begin
            c_reg  <= c_next;
            rv_reg <= rv_next;
            gu_reg <= gu_next;
            gv_reg <= gv_next;
            bu_reg <= bu_next;
        end
        if (adv.adv2) begin
            r_sum_reg <= r_sum_next;
            g_sum_reg <= g_sum_next;
            b_sum_reg <= b_sum_next;
        end
        if (adv.adv3) begin
            pixel_reg <= pixel_next;
        end
    end

    assign pixel_rgb565 = pixel_reg;

endmodule

### sv/yrw_addr.sv
module yrw_addr #(
    parameter int SCREEN_HEIGHT = yrw_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                          aclk,
    input  yrw_pkg::yrw_adv_t             adv,
    input  yrw_pkg::yrw_area_t            area,
    input  logic [yrw_pkg::COORD_W-1:0]   column,
    input  logic [yrw_pkg::COORD_W-1:0]   row,
    output logic                          in_frame,
    output logic [yrw_pkg::ADDR_W-1:0]    fb_address
);
    import yrw_pkg::*;

    localparam logic [ADDR_W-1:0] SH_A = ADDR_W'(SCREEN_HEIGHT);

    logic [ADDR_W-1:0]  col_prod_reg, col_prod_next;
    logic [COORD_W-1:0] flip_row_reg, flip_row_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [ADDR_W-1:0]  out_reg;

    assign in_frame = (column < area.width) && (row < area.height);

    assign col_prod_next = ADDR_W'(column) * SH_A;
    assign flip_row_next = area.height - COORD_W'(1) - row;
    assign addr_next     = col_prod_reg + ADDR_W'(flip_row_reg);

    always_ff @(posedge aclk) begin
        if (adv.adv1) begin
            col_prod_reg <= col_prod_next;
            flip_row_reg <= flip_row_next;
        end
        if (adv.adv2) begin
            addr_reg <= addr_next;
        end
        if (adv.adv3) begin
            out_reg <= addr_reg;
        end
    end

    assign fb_address = out_reg;

endmodule

### sv/yuv_to_rgb565_rotated_writer.sv
// Converts one 4:2:0 source pixel per clock from limited-range BT.601 YUV to
// RGB565 and computes its address in a rotated, vertically flipped,
// column-major framebuffer (column * SCREEN_HEIGHT + visible height - 1 - row).
// The visible area is the configured frame size clipped to the screen; pixels
// outside it are dropped and produce no result. Results leave in input order
// through a three-stage pipeline (products, sums, clamp and pack); a new request
// is taken every cycle while the output side is ready or the pipeline has a free
// slot. Write frame_width (index 0) and frame_height (index 1) only while the
// pipeline is empty.
module yuv_to_rgb565_rotated_writer #(
    parameter int SCREEN_WIDTH  = yrw_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = yrw_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // luma, chroma_blue, chroma_red, column, row
    input  logic [yrw_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // pixel_rgb565, fb_address, zero pad
    output logic [yrw_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [yrw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [yrw_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import yrw_pkg::*;

    logic [SAMPLE_W-1:0] luma, chroma_blue, chroma_red;
    logic [COORD_W-1:0]  column, row;
    logic [PIXEL_W-1:0]  pixel_rgb565;
    logic [ADDR_W-1:0]   fb_address;

    yrw_area_t area;
    yrw_adv_t  adv;
    logic      in_frame;
    logic      ready1, ready2, ready3;

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;

    assign luma        = s_tdata[7:0];
    assign chroma_blue = s_tdata[15:8];
    assign chroma_red  = s_tdata[23:16];
    assign column      = s_tdata[35:24];
    assign row         = s_tdata[47:36];

    assign cfg_ready = 1'b1;

    yrw_cfg #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .area      (area)
    );

    // advance a stage when its slot is empty or the next one moves
    assign ready3 = !v3_reg || m_tready;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;
    assign s_tready = ready1;

    assign adv.adv1 = ready1 && s_tvalid;
    assign adv.adv2 = ready2 && v1_reg;
    assign adv.adv3 = ready3 && v2_reg;

    assign v1_next = ready1 ? (s_tvalid && in_frame) : v1_reg;
    assign v2_next = ready2 ? v1_reg : v2_reg;
    assign v3_next = ready3 ? v2_reg : v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    yrw_color u_color (
        .aclk         (aclk),
        .adv          (adv),
        .luma         (luma),
        .chroma_blue  (chroma_blue),
        .chroma_red   (chroma_red),
        .pixel_rgb565 (pixel_rgb565)
    );

    yrw_addr #(
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_addr (
        .aclk       (aclk),
        .adv        (adv),
        .area       (area),
        .column     (column),
        .row        (row),
        .in_frame   (in_frame),
        .fb_address (fb_address)
    );

    assign m_tvalid = v3_reg;
    assign m_tdata  = {(OUT_DATA_W - PIXEL_W - ADDR_W)'(0), fb_address, pixel_rgb565};

    a_drain_ready : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output side is ready");

    a_empty_ready : assert property (@(posedge aclk) disable iff (!aresetn)
        (!v1_reg && !v2_reg && !v3_reg) |-> s_tready)
        else $error("input stalled with an empty pipeline");

    a_out_source : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(v2_reg))
        else $error("result appeared without a request in the sum stage");

endmodule

### bench/testbench.sv
module testbench;

    import yrw_pkg::*;

    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [SAMPLE_W-1:0] luma;
        logic [SAMPLE_W-1:0] cb;
        logic [SAMPLE_W-1:0] cr;
        logic [COORD_W-1:0]  column;
        logic [COORD_W-1:0]  row;
    } src_pixel_t;

    typedef struct {
        logic [PIXEL_W-1:0] color;
        logic [ADDR_W-1:0]  addr;
    } fb_write_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    src_pixel_t source_pixels[$];
    fb_write_t  expected_writes[$];
    src_pixel_t cur_pixel;
    logic [COORD_W-1:0] frame_w = COORD_W'(FRAME_WIDTH_RST);
    logic [COORD_W-1:0] frame_h = COORD_W'(FRAME_HEIGHT_RST);
    bit quiet_phase = 1'b0;
    int src_gap = 0;
    int sink_stall = 0;
    int mismatches = 0;

    yuv_to_rgb565_rotated_writer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int visible_width();
        return (frame_w < SCREEN_WIDTH_DEF) ? int'(frame_w) : SCREEN_WIDTH_DEF;
    endfunction

    function automatic int visible_height();
        return (frame_h < SCREEN_HEIGHT_DEF) ? int'(frame_h) : SCREEN_HEIGHT_DEF;
    endfunction

    function automatic logic [7:0] clamp_channel(input int acc);
        int s;
        s = acc >>> 8;
        if (s < 0) return 8'd0;
        if (s > 255) return 8'd255;
        return s[7:0];
    endfunction

    function automatic bit pixel_visible(input src_pixel_t p);
        return (int'(p.column) < visible_width()) && (int'(p.row) < visible_height());
    endfunction

    function automatic fb_write_t fb_write_of(input src_pixel_t p);
        fb_write_t w;
        int c, u, v, a;
        logic [7:0] r, g, b;
        c = 298 * (int'(p.luma) - 16) + 128;
        u = int'(p.cb) - 128;
        v = int'(p.cr) - 128;
        r = clamp_channel(c + 409 * v);
        g = clamp_channel(c - 100 * u - 208 * v);
        b = clamp_channel(c + 516 * u);
        w.color = {r[7:3], g[7:2], b[7:3]};
        a = int'(p.column) * SCREEN_HEIGHT_DEF + (visible_height() - 1 - int'(p.row));
        w.addr = a[ADDR_W-1:0];
        return w;
    endfunction

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50) return 0;
        if (k < 85) return $urandom_range(1, 3);
        if (k < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] random_sample();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 8'd0;
        if (k == 1) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic src_pixel_t random_pixel();
        src_pixel_t p;
        int k, w, h;
        w = visible_width();
        h = visible_height();
        k = $urandom_range(0, 99);
        p.luma = random_sample();
        p.cb = random_sample();
        p.cr = random_sample();
        if (k < 70 && w > 0 && h > 0) begin
            p.column = COORD_W'($urandom_range(0, w - 1));
            p.row = COORD_W'($urandom_range(0, h - 1));
        end else if (k < 85) begin
            case ($urandom_range(0, 2))
                0: p.column = COORD_W'(w - 1);
                1: p.column = COORD_W'(w);
                default: p.column = '0;
            endcase
            case ($urandom_range(0, 2))
                0: p.row = COORD_W'(h - 1);
                1: p.row = COORD_W'(h);
                default: p.row = '0;
            endcase
        end else begin
            p.column = COORD_W'($urandom);
            p.row = COORD_W'($urandom);
        end
        return p;
    endfunction

    task automatic push_pixel(input int y, input int u, input int v, input int c, input int r);
        src_pixel_t p;
        p.luma = 8'(y);
        p.cb = 8'(u);
        p.cr = 8'(v);
        p.column = COORD_W'(c);
        p.row = COORD_W'(r);
        source_pixels.push_back(p);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  frame_w = COORD_W'(value);
            REG_FRAME_HEIGHT: frame_h = COORD_W'(value);
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (source_pixels.size() != 0 || s_tvalid || expected_writes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
        mismatches++;
    endtask

    // hold the request until accepted, then idle or advance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid && pixel_visible(cur_pixel)) begin
                expected_writes.push_back(fb_write_of(cur_pixel));
            end
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (source_pixels.size() != 0) begin
                cur_pixel = source_pixels.pop_front();
                s_tdata <= {cur_pixel.row, cur_pixel.column, cur_pixel.cr, cur_pixel.cb,
                            cur_pixel.luma};
                s_tvalid <= 1'b1;
                src_gap = quiet_phase ? 0 : pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_writes.size() == 0) begin
                    report_mismatch("unexpected write", int'(m_tdata), 0);
                end else begin
                    fb_write_t want;
                    want = expected_writes.pop_front();
                    if (m_tdata[PIXEL_W-1:0] !== want.color)
                        report_mismatch("pixel_rgb565", int'(m_tdata[PIXEL_W-1:0]),
                                        int'(want.color));
                    if (m_tdata[PIXEL_W +: ADDR_W] !== want.addr)
                        report_mismatch("fb_address", int'(m_tdata[PIXEL_W +: ADDR_W]),
                                        int'(want.addr));
                end
            end
            if (sink_stall > 0) begin
                sink_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!quiet_phase && $urandom_range(0, 3) == 0) sink_stall = pick_gap();
            end
        end
    end

    initial begin
        int widths[9];
        int heights[9];
        widths = '{1, 4095, 0, 400, 123, 399, 401, 2730, 400};
        heights = '{1, 4095, 240, 0, 77, 239, 241, 1365, 240};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        push_pixel(16, 128, 128, 0, 0);
        push_pixel(235, 128, 128, 399, 239);
        push_pixel(0, 0, 0, 0, 239);
        push_pixel(255, 255, 255, 399, 0);
        push_pixel(0, 255, 255, 1, 1);
        push_pixel(255, 0, 0, 2, 2);
        push_pixel(255, 0, 255, 3, 3);
        push_pixel(0, 255, 0, 4, 4);
        push_pixel(128, 128, 255, 5, 5);
        push_pixel(128, 255, 128, 6, 6);
        push_pixel(81, 90, 240, 200, 120);
        push_pixel(145, 54, 34, 10, 100);
        push_pixel(41, 240, 110, 300, 50);
        push_pixel(100, 100, 100, 400, 0);
        push_pixel(100, 100, 100, 0, 240);
        push_pixel(100, 100, 100, 4095, 4095);
        push_pixel(255, 255, 255, 399, 239);
        push_pixel(0, 0, 0, 0, 0);
        push_pixel(200, 60, 200, 2048, 2048);
        push_pixel(128, 128, 128, 256, 128);
        wait_idle();

        for (int ph = 0; ph < 9; ph++) begin
            write_reg(REG_FRAME_WIDTH, widths[ph]);
            write_reg(REG_FRAME_HEIGHT, heights[ph]);
            quiet_phase = (ph == 3 || ph == 6);
            for (int i = 0; i < 78; i++) source_pixels.push_back(random_pixel());
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("yuv_to_rgb565_rotated_writer regression: pass");
        end else begin
            $display("yuv_to_rgb565_rotated_writer regression: fail");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("yuv_to_rgb565_rotated_writer regression: fail");
        $finish;
    end

endmodule
